// ----- sv/rmf_pkg.sv -----
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and helpers for the rotation-minimizing frame step
// Sequencer state type, fixed-point defaults and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QW            = 31;   // magnitude bits of the reflection coefficient

    typedef enum logic [3:0] {
        S_IDLE,
        S_V1,
        S_LDU,
        S_CC,
        S_CN,
        S_DIV,
        S_DIVW,
        S_APPLY,
        S_RDONE,
        S_CROSS,
        S_DONE
    } rmf_state_t;

    // Clamp a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -66'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/rotation_minimizing_frame_step.sv -----
// ----------------------------------------------------------------------------
// rotation_minimizing_frame_step: double reflection frame propagation
// Reflects the previous up vector across the chord and the tangent
// difference, then forms side = tangent x up, on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | pos_*, dir_*, seed_up_*, first
//  out     | out_valid / out_ready| up_*, side_*
//
//  A first item is accepted, then six cross product multiplies run in turn on the
//  single multiplier before it finishes. A later item first runs three reflections:
//  each takes six dot product multiplies, the bit-serial divider and three multiplies
//  to apply; a zero chord or difference cuts a reflection short after its first three
//  multiplies, and a saturated coefficient ends the divider early.
//  in_ready is high only while idle; a waiting result stalls the end. Reset clears history.
// ----------------------------------------------------------------------------
module rotation_minimizing_frame_step #(
    parameter int FRAC_BITS = rmf_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] seed_up_x,
    input  logic signed [31:0] seed_up_y,
    input  logic signed [31:0] seed_up_z,
    input  logic               first,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] up_x,
    output logic signed [31:0] up_y,
    output logic signed [31:0] up_z,
    output logic signed [31:0] side_x,
    output logic signed [31:0] side_y,
    output logic signed [31:0] side_z
);
    import rmf_pkg::*;

    rmf_state_t state_reg, state_next;

    logic [2:0] idx_reg;
    logic       ph_reg;
    logic [1:0] pass_reg;
    logic       have_prev_reg;
    logic       out_valid_reg;

    logic signed [31:0] pos_reg  [3];
    logic signed [31:0] dir_reg  [3];
    logic signed [31:0] pp_reg   [3];
    logic signed [31:0] pt_reg   [3];
    logic signed [31:0] pu_reg   [3];
    logic signed [31:0] v_reg    [3];
    logic signed [31:0] u_reg    [3];
    logic signed [31:0] rl_reg   [3];
    logic signed [31:0] res_reg  [3];
    logic signed [31:0] upv_reg  [3];
    logic signed [31:0] side_reg [3];
    logic signed [31:0] oup_reg  [3];
    logic signed [31:0] oside_reg[3];

    logic signed [63:0] acc_reg;
    logic [63:0]        c_reg;
    logic [64:0]        num_reg;
    logic               neg_reg;
    logic signed [31:0] q_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_t;
    logic signed [63:0] acc_sum;
    logic [63:0]        sum_mag;
    logic               div_start;
    logic               div_done;
    logic [QW-1:0]      div_q;
    logic               out_free;
    logic [1:0]         ix;

    assign ix       = idx_reg[1:0];
    assign acc_sum  = acc_reg + mul_t;
    assign sum_mag  = acc_sum[63] ? 64'(-acc_sum) : 64'(acc_sum);
    assign out_free = !out_valid_reg || out_ready;

    rmf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .t   (mul_t)
    );

    rmf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (c_reg),
        .done  (div_done),
        .q     (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (first || !have_prev_reg) ? S_CROSS : S_V1;
                end
            end
            S_V1:    state_next = S_LDU;
            S_LDU:   state_next = S_CC;
            S_CC:
            begin
                if (ph_reg && idx_reg == 3'd2)
                begin
                    state_next = (acc_sum <= 0) ? S_RDONE : S_CN;
                end
            end
            S_CN:
            begin
                if (ph_reg && idx_reg == 3'd2)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:   state_next = S_DIVW;
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (ph_reg && idx_reg == 3'd2)
                begin
                    state_next = S_RDONE;
                end
            end
            S_RDONE: state_next = (pass_reg == 2'd2) ? S_CROSS : S_LDU;
            S_CROSS:
            begin
                if (ph_reg && idx_reg == 3'd5)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Multiplier operand select and unit control
    always_comb
    begin
        mul_a     = v_reg[ix];
        mul_b     = v_reg[ix];
        div_start = 1'b0;
        in_ready  = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_CN:    mul_b = u_reg[ix];
            S_DIV:   div_start = 1'b1;
            S_APPLY: mul_a = q_reg;
            S_CROSS:
            begin
                case (idx_reg)
                    3'd0:    begin mul_a = dir_reg[1]; mul_b = upv_reg[2]; end
                    3'd1:    begin mul_a = dir_reg[2]; mul_b = upv_reg[1]; end
                    3'd2:    begin mul_a = dir_reg[2]; mul_b = upv_reg[0]; end
                    3'd3:    begin mul_a = dir_reg[0]; mul_b = upv_reg[2]; end
                    3'd4:    begin mul_a = dir_reg[0]; mul_b = upv_reg[1]; end
                    default: begin mul_a = dir_reg[1]; mul_b = upv_reg[0]; end
                endcase
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            ph_reg        <= 1'b0;
            pass_reg      <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                idx_reg <= '0;
                ph_reg  <= 1'b0;
            end
            else if (state_reg == S_CC || state_reg == S_CN ||
                     state_reg == S_APPLY || state_reg == S_CROSS)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
            if (state_reg == S_V1)
            begin
                pass_reg <= 2'd0;
            end
            else if (state_reg == S_RDONE)
            begin
                pass_reg <= pass_reg + 2'd1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                have_prev_reg <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_reg <= '{pos_x, pos_y, pos_z};
                    dir_reg <= '{dir_x, dir_y, dir_z};
                    upv_reg <= '{seed_up_x, seed_up_y, seed_up_z};
                end
            end
            S_V1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v_reg[i] <= sat32(66'(pos_reg[i]) - 66'(pp_reg[i]));
                end
            end
            S_LDU:
            begin
                acc_reg <= '0;
                case (pass_reg)
                    2'd0:    u_reg <= pu_reg;
                    2'd1:    u_reg <= pt_reg;
                    default: u_reg <= rl_reg;
                endcase
            end
            S_CC:
            begin
                if (ph_reg)
                begin
                    if (idx_reg == 3'd2)
                    begin
                        acc_reg <= '0;
                        c_reg   <= 64'(acc_sum);
                        res_reg <= u_reg;
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                    end
                end
            end
            S_CN:
            begin
                if (ph_reg)
                begin
                    acc_reg <= acc_sum;
                    if (idx_reg == 3'd2)
                    begin
                        neg_reg <= acc_sum[63];
                        num_reg <= {sum_mag, 1'b0};
                    end
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    q_reg <= neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
                end
            end
            S_APPLY:
            begin
                if (ph_reg)
                begin
                    res_reg[ix] <= sat32(66'(u_reg[ix]) - 66'(mul_t));
                end
            end
            S_RDONE:
            begin
                case (pass_reg)
                    2'd0: rl_reg <= res_reg;
                    2'd1:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            v_reg[i] <= sat32(66'(dir_reg[i]) - 66'(res_reg[i]));
                        end
                    end
                    default: upv_reg <= res_reg;
                endcase
            end
            S_CROSS:
            begin
                if (ph_reg)
                begin
                    if (!idx_reg[0])
                    begin
                        acc_reg <= mul_t;
                    end
                    else
                    begin
                        side_reg[idx_reg[2:1]] <= sat32(66'(acc_reg) - 66'(mul_t));
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    oup_reg   <= upv_reg;
                    oside_reg <= side_reg;
                    pp_reg    <= pos_reg;
                    pt_reg    <= dir_reg;
                    pu_reg    <= upv_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign up_x      = oup_reg[0];
    assign up_y      = oup_reg[1];
    assign up_z      = oup_reg[2];
    assign side_x    = oside_reg[0];
    assign side_y    = oside_reg[1];
    assign side_z    = oside_reg[2];

    // Divider completes only while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVW)
        else $error("divider done outside wait state");

    // An accepted transaction leaves idle on the next cycle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after accept");

    // Finishing an item presents a result and records history
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> out_valid && have_prev_reg)
        else $error("finished item without result");

endmodule

// ----- sv/rmf_mul.sv -----
// ----------------------------------------------------------------------------
// rmf_mul: shared fixed-point multiplier
// Registers the full 64-bit product; the scaled result (truncated toward zero)
// is available in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module rmf_mul #(
    parameter int FRAC_BITS = rmf_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] t
);
    import rmf_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted;
    logic               fix;

    // Hold the product of the presented operands
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // Scale down, rounding negative values toward zero
    assign shifted = prod_reg >>> FRAC_BITS;
    assign fix     = prod_reg[63] && (|prod_reg[FRAC_BITS-1:0]);
    assign t       = shifted + {63'd0, fix};

endmodule

// ----- sv/rmf_div.sv -----
// ----------------------------------------------------------------------------
// rmf_div: iterative fixed-point ratio unit
// Computes min(floor(num * 2^FRAC_BITS / den), 2^31-1), one quotient bit per
// cycle after a saturation check that ends the division early on overflow.
// ----------------------------------------------------------------------------
module rmf_div #(
    parameter int FRAC_BITS = rmf_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [64:0]               num,
    input  logic [63:0]               den,
    output logic                      done,
    output logic [rmf_pkg::QW-1:0]    q
);
    import rmf_pkg::*;

    localparam int DW = 97;

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dsr_reg;
    logic [QW-1:0] q_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          ge;

    assign ge = (rem_reg >= dsr_reg);

    // Control: step counter and completion flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(QW + 1);
            end
            else if (busy_reg)
            begin
                if ((cnt_reg == 6'(QW + 1) && ge) || cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // Datapath: shift divisor down, subtract where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(num) << FRAC_BITS;
            dsr_reg <= DW'(den) << QW;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'(QW + 1))
            begin
                if (ge)
                begin
                    q_reg <= '1;
                end
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                end
                q_reg <= {q_reg[QW-2:0], ge};
            end
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ----- tb/sv/rotation_minimizing_frame_step_tb.sv -----
// ----------------------------------------------------------------------------
// rotation_minimizing_frame_step_tb: self-checking bench for the frame step
// Drives curve samples through a valid/ready channel and checks every frame
// (up and side vectors) against a fixed-point double reflection predictor, or
// against a typed frame for some directed rows. A directed table comes first,
// then random curves mixed with noise samples, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module rotation_minimizing_frame_step_tb;

    import rmf_pkg::*;

    localparam int  FB          = FRAC_BITS_DEF;
    localparam int  STALL_LIMIT = 20000;
    localparam int  DRAIN_WAIT  = 400;
    localparam int  RAND_ITEMS  = 1430;
    localparam int  ONE         = 65536;
    localparam int  MX          = 2147483647;
    localparam int  MN          = -2147483647 - 1;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [31:0] dx, dy, dz;
        logic signed [31:0] sx, sy, sz;
        logic               first;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] ux, uy, uz;
        logic signed [31:0] wx, wy, wz;
    } frame_t;

    typedef struct packed {
        sample_t s;
        logic    typed;
        frame_t  f;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] dir_x, dir_y, dir_z;
    logic signed [31:0] seed_up_x, seed_up_y, seed_up_z;
    logic               first;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] up_x, up_y, up_z;
    logic signed [31:0] side_x, side_y, side_z;

    frame_t  frames_due[$];
    row_t    stim_rows[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      quiet_cycles = 0;
    bit      failed = 1'b0;

    // frame predictor state
    longint  fp_pos[3];
    longint  fp_tan[3];
    longint  fp_up[3];
    bit      fp_have;

    rotation_minimizing_frame_step i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .seed_up_x (seed_up_x),
        .seed_up_y (seed_up_y),
        .seed_up_z (seed_up_z),
        .first     (first),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z),
        .side_x    (side_x),
        .side_y    (side_y),
        .side_z    (side_z)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) / (longint'(1) << FB);
    endfunction

    function automatic longint dot3(input longint a[3], input longint b[3]);
        return qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]);
    endfunction

    // 2(v.u)/(v.v) with truncated, saturated magnitude and the sign of v.u
    function automatic longint coeff(input longint n, input longint c);
        longint unsigned mag;
        longint unsigned uc;
        longint unsigned ip;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : n;
        uc  = c;
        ip  = mag / uc;
        if (ip >= (64'd1 << (31 - FB)))
        begin
            q = 64'd2147483647;
        end
        else
        begin
            q = (ip << FB) + (((mag % uc) << FB) / uc);
            if (q > 64'd2147483647)
            begin
                q = 64'd2147483647;
            end
        end
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic reflect_across(input longint u[3], input longint v[3],
                                  output longint r[3]);
        longint c;
        longint q;
        c = dot3(v, v);
        if (c <= 0)
        begin
            r = u;
        end
        else
        begin
            q = coeff(2 * dot3(v, u), c);
            for (int i = 0; i < 3; i++)
            begin
                r[i] = clamp32(u[i] - (q * v[i]) / (longint'(1) << FB));
            end
        end
    endtask

    task automatic predict_frame(input sample_t s, output frame_t f);
        longint p[3], d[3], u[3], w[3];
        longint v1[3], v2[3], ru[3], rt[3];
        p = '{s.px, s.py, s.pz};
        d = '{s.dx, s.dy, s.dz};
        if (s.first || !fp_have)
        begin
            u = '{s.sx, s.sy, s.sz};
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                v1[i] = clamp32(p[i] - fp_pos[i]);
            end
            reflect_across(fp_up, v1, ru);
            reflect_across(fp_tan, v1, rt);
            for (int i = 0; i < 3; i++)
            begin
                v2[i] = clamp32(d[i] - rt[i]);
            end
            reflect_across(ru, v2, u);
        end
        w[0] = clamp32(qmul(d[1], u[2]) - qmul(d[2], u[1]));
        w[1] = clamp32(qmul(d[2], u[0]) - qmul(d[0], u[2]));
        w[2] = clamp32(qmul(d[0], u[1]) - qmul(d[1], u[0]));
        fp_pos  = p;
        fp_tan  = d;
        fp_up   = u;
        fp_have = 1'b1;
        f = '{32'(u[0]), 32'(u[1]), 32'(u[2]), 32'(w[0]), 32'(w[1]), 32'(w[2])};
    endtask

    // ---------------------------------------------------------------- sender
    task automatic send_sample(input row_t r);
        frame_t f;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pos_x     <= r.s.px;
        pos_y     <= r.s.py;
        pos_z     <= r.s.pz;
        dir_x     <= r.s.dx;
        dir_y     <= r.s.dy;
        dir_z     <= r.s.dz;
        seed_up_x <= r.s.sx;
        seed_up_y <= r.s.sy;
        seed_up_z <= r.s.sz;
        first     <= r.s.first;
        // hold until the transaction is taken at the coming edge
        do
        begin
            @(negedge clk);
        end
        while (!in_ready);
        predict_frame(r.s, f);
        frames_due.insert(frames_due.size(), r.typed ? r.f : f);
        @(posedge clk);
    endtask

    function automatic sample_t mk(input longint px, py, pz, dx, dy, dz,
                                   input longint sx, sy, sz, input bit fst);
        return '{32'(px), 32'(py), 32'(pz), 32'(dx), 32'(dy), 32'(dz),
                 32'(sx), 32'(sy), 32'(sz), fst};
    endfunction

    function automatic logic signed [31:0] jitter(input int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // ---------------------------------------------------------------- receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // check each result transaction and watch for a stuck block
    always @(negedge clk)
    begin
        frame_t e;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("frame with none expected: up %0d %0d %0d", up_x, up_y, up_z);
                    failed = 1'b1;
                end
                else
                begin
                    e = frames_due.pop_front();
                    if (up_x !== e.ux)
                    begin
                        $error("up_x: expected %0d, got %0d", e.ux, up_x);
                        failed = 1'b1;
                    end
                    if (up_y !== e.uy)
                    begin
                        $error("up_y: expected %0d, got %0d", e.uy, up_y);
                        failed = 1'b1;
                    end
                    if (up_z !== e.uz)
                    begin
                        $error("up_z: expected %0d, got %0d", e.uz, up_z);
                        failed = 1'b1;
                    end
                    if (side_x !== e.wx)
                    begin
                        $error("side_x: expected %0d, got %0d", e.wx, side_x);
                        failed = 1'b1;
                    end
                    if (side_y !== e.wy)
                    begin
                        $error("side_y: expected %0d, got %0d", e.wy, side_y);
                        failed = 1'b1;
                    end
                    if (side_z !== e.wz)
                    begin
                        $error("side_z: expected %0d, got %0d", e.wz, side_z);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial
    begin
        sample_t s;
        row_t    r;
        longint  cp[3];
        int      seg_left;
        int      wait_cnt;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        {pos_x, pos_y, pos_z, dir_x, dir_y, dir_z} = '0;
        {seed_up_x, seed_up_y, seed_up_z}          = '0;
        first         = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 83;
        fp_pos        = '{0, 0, 0};
        fp_tan        = '{0, 0, 0};
        fp_up         = '{0, 0, 0};
        fp_have       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: no history after reset, zero chord, extremes
        stim_rows.insert(stim_rows.size(), '{mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0), 1'b1,
                              '{0, ONE, 0, 0, 0, ONE}});
        stim_rows.insert(stim_rows.size(), '{mk(0, 0, 0, ONE, 0, 0, MX, MN, 7, 0), 1'b1,
                              '{0, ONE, 0, 0, 0, ONE}});
        stim_rows.insert(stim_rows.size(), '{mk(5, 6, 7, 0, 0, 0, MX, MN, MX, 1), 1'b1,
                              '{MX, MN, MX, 0, 0, 0}});
        stim_rows.insert(stim_rows.size(), '{mk(MN, MN, MN, MX, MX, MX, MN, MN, MN, 1),
                              1'b1, '{MN, MN, MN, 0, 0, 0}});
        stim_rows.insert(stim_rows.size(),
                         '{mk(MX, MX, MX, MN, 0, MX, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(MN, MN, MN, MX, MN, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(MX, 0, MN, MN, MN, MN, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(0, 0, 0, ONE, 0, 0, 0, 0, ONE, 1), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(2 * ONE, ONE, 0, 46341, 46341, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(2 * ONE, 2 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(2 * ONE, 2 * ONE, ONE, 0, 0, ONE, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(2 * ONE, 2 * ONE, ONE, 0, 0, -ONE, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(3, -3, 1, 1, -1, 1, 1, 1, 1, 1), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(4, -2, 1, -1, 1, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1), 1'b0, '0});
        stim_rows.insert(stim_rows.size(),
                         '{mk(MX, MX, MX, MX, MX, MX, 0, 0, 0, 0), 1'b0, '0});
        foreach (stim_rows[i])
        begin
            send_sample(stim_rows[i]);
        end

        // random curves with noise, idling pattern changes by thirds
        seg_left = 0;
        cp = '{0, 0, 0};
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 3)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 34;
            end
            if (n == 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(9) == 0)
            begin
                s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 1'($urandom)};
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(4, 30);
                    cp = '{jitter(200 * ONE), jitter(200 * ONE), jitter(200 * ONE)};
                    s = mk(cp[0], cp[1], cp[2], jitter(ONE), jitter(ONE), jitter(ONE),
                           jitter(ONE), jitter(ONE), jitter(ONE), 1);
                end
                else
                begin
                    // hold position now and then to hit the skipped reflection
                    if ($urandom_range(7) != 0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            cp[i] = cp[i] + jitter(ONE);
                        end
                    end
                    s = mk(cp[0], cp[1], cp[2], jitter(ONE), jitter(ONE), jitter(ONE),
                           $urandom, $urandom, $urandom, 0);
                    if ($urandom_range(7) == 0)
                    begin
                        s.dx = 32'(fp_tan[0]);
                        s.dy = 32'(fp_tan[1]);
                        s.dz = 32'(fp_tan[2]);
                    end
                end
                seg_left--;
            end
            r = '{s, 1'b0, '0};
            send_sample(r);
        end
        in_valid <= 1'b0;

        // drain outstanding frames, then let the block settle
        wait_cnt = 0;
        while (frames_due.size() != 0 && wait_cnt < 50 * STALL_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (!failed && frames_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            if (frames_due.size() != 0)
            begin
                $error("%0d frames never arrived", frames_due.size());
            end
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
